// File: rtl/gated_delta_rule_state_update_top_assert.svh
// Assertion macros for the gated delta-rule state update block.
// Each macro expands to one labeled concurrent assertion, clocked on clock
// and disabled while reset is high.
`ifndef GATED_DELTA_RULE_STATE_UPDATE_TOP_ASSERT_SVH
`define GATED_DELTA_RULE_STATE_UPDATE_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define GDR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define GDR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared types and constants of the gated delta-rule state update block:
// operation and result codes, operand selects and controller/datapath links.
// ----------------------------------------------------------------------------
package gdr_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_STATE = 2'd0,
      OP_WRITE_QK    = 2'd1,
      OP_COMMIT      = 2'd2,
      OP_READ_STATE  = 2'd3
   } op_type;

   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_COMMIT = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [7:0]  KEY_LENGTH_RESET = 8'd128;
   localparam logic [31:0] FP_QUIET_BIT     = 32'h0040_0000;
   localparam logic [31:0] FP_DEFAULT_NAN   = 32'hFFC0_0000;

   // FPU operand A select
   typedef enum logic [2:0] {
      OPA_ROW,
      OPA_ACC,
      OPA_VALUE,
      OPA_KEY,
      OPA_RESULT
   } opa_type;

   // FPU operand B select
   typedef enum logic [2:0] {
      OPB_DECAY,
      OPB_KEY,
      OPB_QUERY,
      OPB_RESULT,
      OPB_NEG_ACC,
      OPB_BETA,
      OPB_DELTA
   } opb_type;

   typedef struct packed {
      logic    ld_req;
      logic    use_col;
      logic    mem_rd;
      logic    st_wr;
      logic    st_from_fpu;
      logic    qk_wr;
      logic    fpu_start;
      logic    fpu_add;
      opa_type opa;
      opb_type opb;
      logic    ld_acc;
      logic    ld_delta;
      logic    idx_clr;
      logic    idx_inc;
      logic    ld_rsp;
   } gdr_cmd_type;

   typedef struct packed {
      op_type op;
      logic   row_ok;
      logic   col_ok;
      logic   len_zero;
      logic   idx_first;
      logic   idx_last;
      logic   fpu_done;
   } gdr_status_type;

endpackage

// File: rtl/gdr_ram.sv
// ----------------------------------------------------------------------------
// gdr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/gdr_fpu.sv
// ----------------------------------------------------------------------------
// gdr_fpu
// Three-stage FP32 multiply/add unit, round to nearest even, full subnormal
// support. Stage 1 multiplies or aligns and adds, stage 2 finds the leading
// one, stage 3 shifts and rounds.
// ----------------------------------------------------------------------------
module gdr_fpu
   import gdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_add,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] result,
   output logic        done
);

   // ---------------- stage 1 ----------------
   logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [23:0] ma, mb;
   logic [9:0]  ea, eb;
   logic        s1_spec_in, s1_sign_in, s1_zsign_in;
   logic [31:0] s1_spec_res_in;
   logic [47:0] s1_m_in;
   logic signed [10:0] s1_t_in;
   logic        a_big;
   logic [23:0] mx, my;
   logic [9:0]  ex, ey;
   logic        sx, sy;
   logic [7:0]  dexp;
   logic [4:0]  dd;
   logic [53:0] ysh;
   logic [26:0] yal;
   logic [27:0] sum28;

   always_comb begin
      sa     = a[31];
      sb     = b[31];
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      ma     = {a[30:23] != 8'd0, a[22:0]};
      mb     = {b[30:23] != 8'd0, b[22:0]};
      ea     = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
      eb     = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};

      // order operands by magnitude for the adder
      a_big = (a[30:0] >= b[30:0]);
      mx    = a_big ? ma : mb;
      my    = a_big ? mb : ma;
      ex    = a_big ? ea : eb;
      ey    = a_big ? eb : ea;
      sx    = a_big ? sa : sb;
      sy    = a_big ? sb : sa;
      dexp  = 8'(ex - ey);
      dd    = (dexp > 8'd28) ? 5'd28 : dexp[4:0];
      ysh   = {my, 3'b000, 27'd0} >> dd;
      yal   = ysh[53:27] | {26'd0, |ysh[26:0]};
      if (sx != sy) begin
         sum28 = {1'b0, mx, 3'b000} - {1'b0, yal};
      end else begin
         sum28 = {1'b0, mx, 3'b000} + {1'b0, yal};
      end

      s1_spec_in     = 1'b0;
      s1_spec_res_in = 32'd0;
      if (is_add) begin
         s1_m_in     = {sum28, 20'd0};
         s1_t_in     = $signed({1'b0, ex}) + 11'sd1;
         s1_sign_in  = sx;
         s1_zsign_in = (sa == sb) ? sa : 1'b0;
      end else begin
         s1_m_in     = ma * mb;
         s1_t_in     = $signed({1'b0, ea}) + $signed({1'b0, eb}) - 11'sd126;
         s1_sign_in  = sa ^ sb;
         s1_zsign_in = sa ^ sb;
      end

      // NaN, infinity and invalid cases bypass the datapath
      if (a_nan) begin
         s1_spec_in     = 1'b1;
         s1_spec_res_in = a | FP_QUIET_BIT;
      end else if (b_nan) begin
         s1_spec_in     = 1'b1;
         s1_spec_res_in = b | FP_QUIET_BIT;
      end else if (is_add) begin
         if (a_inf && b_inf && (sa != sb)) begin
            s1_spec_in     = 1'b1;
            s1_spec_res_in = FP_DEFAULT_NAN;
         end else if (a_inf) begin
            s1_spec_in     = 1'b1;
            s1_spec_res_in = a;
         end else if (b_inf) begin
            s1_spec_in     = 1'b1;
            s1_spec_res_in = b;
         end
      end else begin
         if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            s1_spec_in     = 1'b1;
            s1_spec_res_in = FP_DEFAULT_NAN;
         end else if (a_inf || b_inf) begin
            s1_spec_in     = 1'b1;
            s1_spec_res_in = {sa ^ sb, 8'hFF, 23'd0};
         end
      end
   end

   logic               s1_valid_ff, s1_spec_ff, s1_sign_ff, s1_zsign_ff;
   logic [31:0]        s1_spec_res_ff;
   logic [47:0]        s1_m_ff;
   logic signed [10:0] s1_t_ff;

   // ---------------- stage 2 ----------------
   logic [5:0]         lz;
   logic signed [10:0] t_minus;
   logic               s2_left_in;
   logic [5:0]         s2_shamt_in;
   logic signed [10:0] s2_expf_in;
   logic signed [10:0] rs;

   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (s1_m_ff[i]) begin
            lz = 6'(47 - i);
         end
      end
      t_minus = s1_t_ff - $signed({5'd0, lz});
      rs      = 11'sd1 - s1_t_ff;
      if (t_minus >= 11'sd1) begin
         s2_left_in  = 1'b1;
         s2_shamt_in = lz;
         s2_expf_in  = t_minus;
      end else if (s1_t_ff >= 11'sd1) begin
         s2_left_in  = 1'b1;
         s2_shamt_in = 6'(s1_t_ff - 11'sd1);
         s2_expf_in  = 11'sd0;
      end else begin
         s2_left_in  = 1'b0;
         s2_shamt_in = (rs > 11'sd63) ? 6'd63 : rs[5:0];
         s2_expf_in  = 11'sd0;
      end
   end

   logic               s2_valid_ff, s2_spec_ff, s2_sign_ff, s2_zsign_ff, s2_left_ff;
   logic [31:0]        s2_spec_res_ff;
   logic [47:0]        s2_m_ff;
   logic [5:0]         s2_shamt_ff;
   logic signed [10:0] s2_expf_ff;

   // ---------------- stage 3 ----------------
   logic [111:0] rsh;
   logic [47:0]  mn;
   logic         lo_st, g, st, up;
   logic [23:0]  mant;
   logic [30:0]  mag;
   logic [31:0]  res_in;

   always_comb begin
      rsh   = {s2_m_ff, 64'd0} >> s2_shamt_ff;
      if (s2_left_ff) begin
         mn    = s2_m_ff << s2_shamt_ff;
         lo_st = 1'b0;
      end else begin
         mn    = rsh[111:64];
         lo_st = |rsh[63:0];
      end
      mant = mn[47:24];
      g    = mn[23];
      st   = (|mn[22:0]) | lo_st;
      up   = g & (st | mant[0]);
      mag  = {s2_expf_ff[7:0], mant[22:0]} + {30'd0, up};
      if (s2_spec_ff) begin
         res_in = s2_spec_res_ff;
      end else if (s2_m_ff == 48'd0) begin
         res_in = {s2_zsign_ff, 31'd0};
      end else if (s2_expf_ff >= 11'sd255) begin
         res_in = {s2_sign_ff, 8'hFF, 23'd0};
      end else begin
         res_in = {s2_sign_ff, mag};
      end
   end

   logic        s3_valid_ff;
   logic [31:0] result_ff;

   // advance the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (start) begin
         s1_spec_ff     <= s1_spec_in;
         s1_spec_res_ff <= s1_spec_res_in;
         s1_sign_ff     <= s1_sign_in;
         s1_zsign_ff    <= s1_zsign_in;
         s1_m_ff        <= s1_m_in;
         s1_t_ff        <= s1_t_in;
      end
      if (s1_valid_ff) begin
         s2_spec_ff     <= s1_spec_ff;
         s2_spec_res_ff <= s1_spec_res_ff;
         s2_sign_ff     <= s1_sign_ff;
         s2_zsign_ff    <= s1_zsign_ff;
         s2_m_ff        <= s1_m_ff;
         s2_left_ff     <= s2_left_in;
         s2_shamt_ff    <= s2_shamt_in;
         s2_expf_ff     <= s2_expf_in;
      end
      if (s2_valid_ff) begin
         result_ff <= res_in;
      end
   end

   assign result = result_ff;
   assign done   = s3_valid_ff;

endmodule

// File: rtl/gdr_datapath.sv
// ----------------------------------------------------------------------------
// gdr_datapath
// Transaction registers, state/query/key memories, the shared FPU, the
// accumulator and the response register.
// ----------------------------------------------------------------------------
module gdr_datapath
   import gdr_pkg::*;
#(
   parameter int ROWS    = 4,
   parameter int KEY_DIM = 128
) (
   input  logic           clock,
   input  logic           reset,
   input  gdr_cmd_type    cmd,
   output gdr_status_type status,
   input  logic [1:0]     req_operation,
   input  logic [1:0]     req_row,
   input  logic [6:0]     req_column,
   input  logic [31:0]    req_state_word,
   input  logic [31:0]    req_query_word,
   input  logic [31:0]    req_key_word,
   input  logic [31:0]    req_value_word,
   input  logic [31:0]    req_decay_word,
   input  logic [31:0]    req_beta_word,
   input  logic           csr_wr,
   input  logic [7:0]     csr_key_length,
   output logic [31:0]    rsp_result_word,
   output logic [1:0]     rsp_result_kind
);

   localparam int KW  = $clog2(KEY_DIM);
   localparam int LW  = $clog2(KEY_DIM + 1);
   localparam int SD  = ROWS * KEY_DIM;
   localparam int SAW = $clog2(SD);

   op_type      op_ff;
   logic [1:0]  row_ff;
   logic [6:0]  col_ff;
   logic [31:0] state_word_ff, query_ff, key_ff, value_ff, decay_ff, beta_ff;
   logic [7:0]  key_length_ff;
   logic [LW-1:0] idx_ff;
   logic [31:0] acc_ff, delta_ff;
   logic [31:0] rsp_word_ff;
   logic [1:0]  rsp_kind_ff;

   logic [LW-1:0]  len;
   logic           row_ok, col_ok;
   logic [KW-1:0]  elem_col;
   logic [SAW-1:0] st_addr;
   logic [31:0]    st_rd, q_rd, k_rd, fpu_res, opa, opb, neg_acc;
   logic           fpu_done;

   // effective key length and range checks
   always_comb begin
      len      = (int'(key_length_ff) < KEY_DIM) ? LW'(key_length_ff) : LW'(KEY_DIM);
      row_ok   = int'(row_ff) < ROWS;
      col_ok   = int'(col_ff) < KEY_DIM;
      elem_col = cmd.use_col ? KW'(col_ff) : idx_ff[KW-1:0];
      st_addr  = SAW'(int'(row_ff) * KEY_DIM + int'(elem_col));
   end

   gdr_ram #(.WIDTH(32), .DEPTH(SD)) u_state_ram (
      .clock (clock),
      .we    (cmd.st_wr),
      .waddr (st_addr),
      .wdata (cmd.st_from_fpu ? fpu_res : state_word_ff),
      .re    (cmd.mem_rd),
      .raddr (st_addr),
      .rdata (st_rd)
   );

   gdr_ram #(.WIDTH(32), .DEPTH(KEY_DIM)) u_query_ram (
      .clock (clock),
      .we    (cmd.qk_wr),
      .waddr (elem_col),
      .wdata (query_ff),
      .re    (cmd.mem_rd),
      .raddr (elem_col),
      .rdata (q_rd)
   );

   gdr_ram #(.WIDTH(32), .DEPTH(KEY_DIM)) u_key_ram (
      .clock (clock),
      .we    (cmd.qk_wr),
      .waddr (elem_col),
      .wdata (key_ff),
      .re    (cmd.mem_rd),
      .raddr (elem_col),
      .rdata (k_rd)
   );

   // select FPU operands; a NaN projection passes unnegated
   always_comb begin
      if ((acc_ff[30:23] == 8'hFF) && (acc_ff[22:0] != 23'd0)) begin
         neg_acc = acc_ff;
      end else begin
         neg_acc = {~acc_ff[31], acc_ff[30:0]};
      end
      case (cmd.opa)
         OPA_ROW:    opa = st_rd;
         OPA_ACC:    opa = acc_ff;
         OPA_VALUE:  opa = value_ff;
         OPA_KEY:    opa = k_rd;
         OPA_RESULT: opa = fpu_res;
         default:    opa = fpu_res;
      endcase
      case (cmd.opb)
         OPB_DECAY:   opb = decay_ff;
         OPB_KEY:     opb = k_rd;
         OPB_QUERY:   opb = q_rd;
         OPB_RESULT:  opb = fpu_res;
         OPB_NEG_ACC: opb = neg_acc;
         OPB_BETA:    opb = beta_ff;
         OPB_DELTA:   opb = delta_ff;
         default:     opb = fpu_res;
      endcase
   end

   gdr_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.fpu_start),
      .is_add (cmd.fpu_add),
      .a      (opa),
      .b      (opb),
      .result (fpu_res),
      .done   (fpu_done)
   );

   // hold key length, element counter and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LENGTH_RESET;
         idx_ff        <= '0;
      end else begin
         if (csr_wr) begin
            key_length_ff <= csr_key_length;
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + LW'(1);
         end
      end
      if (cmd.ld_req) begin
         op_ff         <= op_type'(req_operation);
         row_ff        <= req_row;
         col_ff        <= req_column;
         state_word_ff <= req_state_word;
         query_ff      <= req_query_word;
         key_ff        <= req_key_word;
         value_ff      <= req_value_word;
         decay_ff      <= req_decay_word;
         beta_ff       <= req_beta_word;
      end
      if (cmd.ld_acc) begin
         acc_ff <= fpu_res;
      end
      if (cmd.ld_delta) begin
         delta_ff <= fpu_res;
      end
      if (cmd.ld_rsp) begin
         case (op_ff)
            OP_COMMIT: begin
               rsp_kind_ff <= KIND_COMMIT;
               rsp_word_ff <= (row_ok && (len != '0)) ? acc_ff : 32'd0;
            end
            OP_READ_STATE: begin
               rsp_kind_ff <= KIND_READ;
               rsp_word_ff <= (row_ok && col_ok) ? st_rd : 32'd0;
            end
            default: begin
               rsp_kind_ff <= KIND_ACK;
               rsp_word_ff <= 32'd0;
            end
         endcase
      end
   end

   always_comb begin
      status.op        = op_ff;
      status.row_ok    = row_ok;
      status.col_ok    = col_ok;
      status.len_zero  = (len == '0);
      status.idx_first = (idx_ff == '0);
      status.idx_last  = ((idx_ff + LW'(1)) == len);
      status.fpu_done  = fpu_done;
   end

   assign rsp_result_word = rsp_word_ff;
   assign rsp_result_kind = rsp_kind_ff;

endmodule

// File: rtl/gdr_controller.sv
// ----------------------------------------------------------------------------
// gdr_controller
// Sequencer: accepts a transaction, dispatches element writes and reads, and
// walks a row commit through its scale/projection and update/output passes.
// ----------------------------------------------------------------------------
module gdr_controller
   import gdr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  gdr_status_type status,
   output gdr_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_A_READ,
      ST_A_SCALE,
      ST_A_SCALE_WAIT,
      ST_A_PROD_WAIT,
      ST_A_SUM_WAIT,
      ST_A_NEXT,
      ST_D_SUB,
      ST_D_SUB_WAIT,
      ST_D_MUL_WAIT,
      ST_B_READ,
      ST_B_UPD,
      ST_B_UPD_WAIT,
      ST_B_ADD_WAIT,
      ST_B_PROD_WAIT,
      ST_B_SUM_WAIT,
      ST_B_NEXT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.use_col = 1'b1;
            state_in    = ST_FINISH;
            case (status.op)
               OP_WRITE_STATE: cmd.st_wr  = status.row_ok && status.col_ok;
               OP_WRITE_QK:    cmd.qk_wr  = status.col_ok;
               OP_READ_STATE:  cmd.mem_rd = 1'b1;
               OP_COMMIT: begin
                  if (status.row_ok && !status.len_zero) begin
                     cmd.idx_clr = 1'b1;
                     state_in    = ST_A_READ;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end
         // pass one: scale by decay, accumulate projection onto key
         ST_A_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_A_SCALE;
         end
         ST_A_SCALE: begin
            cmd.fpu_start = 1'b1;
            cmd.opa       = OPA_ROW;
            cmd.opb       = OPB_DECAY;
            state_in      = ST_A_SCALE_WAIT;
         end
         ST_A_SCALE_WAIT: begin
            if (status.fpu_done) begin
               cmd.st_wr       = 1'b1;
               cmd.st_from_fpu = 1'b1;
               cmd.fpu_start   = 1'b1;
               cmd.opa         = OPA_RESULT;
               cmd.opb         = OPB_KEY;
               state_in        = ST_A_PROD_WAIT;
            end
         end
         ST_A_PROD_WAIT: begin
            if (status.fpu_done) begin
               if (status.idx_first) begin
                  cmd.ld_acc = 1'b1;
                  state_in   = ST_A_NEXT;
               end else begin
                  cmd.fpu_start = 1'b1;
                  cmd.fpu_add   = 1'b1;
                  cmd.opa       = OPA_ACC;
                  cmd.opb       = OPB_RESULT;
                  state_in      = ST_A_SUM_WAIT;
               end
            end
         end
         ST_A_SUM_WAIT: begin
            if (status.fpu_done) begin
               cmd.ld_acc = 1'b1;
               state_in   = ST_A_NEXT;
            end
         end
         ST_A_NEXT: begin
            if (status.idx_last) begin
               state_in = ST_D_SUB;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_A_READ;
            end
         end
         // delta = (value - projection) * beta
         ST_D_SUB: begin
            cmd.fpu_start = 1'b1;
            cmd.fpu_add   = 1'b1;
            cmd.opa       = OPA_VALUE;
            cmd.opb       = OPB_NEG_ACC;
            state_in      = ST_D_SUB_WAIT;
         end
         ST_D_SUB_WAIT: begin
            if (status.fpu_done) begin
               cmd.fpu_start = 1'b1;
               cmd.opa       = OPA_RESULT;
               cmd.opb       = OPB_BETA;
               state_in      = ST_D_MUL_WAIT;
            end
         end
         ST_D_MUL_WAIT: begin
            if (status.fpu_done) begin
               cmd.ld_delta = 1'b1;
               cmd.idx_clr  = 1'b1;
               state_in     = ST_B_READ;
            end
         end
         // pass two: add key*delta, accumulate output onto query
         ST_B_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_B_UPD;
         end
         ST_B_UPD: begin
            cmd.fpu_start = 1'b1;
            cmd.opa       = OPA_KEY;
            cmd.opb       = OPB_DELTA;
            state_in      = ST_B_UPD_WAIT;
         end
         ST_B_UPD_WAIT: begin
            if (status.fpu_done) begin
               cmd.fpu_start = 1'b1;
               cmd.fpu_add   = 1'b1;
               cmd.opa       = OPA_ROW;
               cmd.opb       = OPB_RESULT;
               state_in      = ST_B_ADD_WAIT;
            end
         end
         ST_B_ADD_WAIT: begin
            if (status.fpu_done) begin
               cmd.st_wr       = 1'b1;
               cmd.st_from_fpu = 1'b1;
               cmd.fpu_start   = 1'b1;
               cmd.opa         = OPA_RESULT;
               cmd.opb         = OPB_QUERY;
               state_in        = ST_B_PROD_WAIT;
            end
         end
         ST_B_PROD_WAIT: begin
            if (status.fpu_done) begin
               if (status.idx_first) begin
                  cmd.ld_acc = 1'b1;
                  state_in   = ST_B_NEXT;
               end else begin
                  cmd.fpu_start = 1'b1;
                  cmd.fpu_add   = 1'b1;
                  cmd.opa       = OPA_ACC;
                  cmd.opb       = OPB_RESULT;
                  state_in      = ST_B_SUM_WAIT;
               end
            end
         end
         ST_B_SUM_WAIT: begin
            if (status.fpu_done) begin
               cmd.ld_acc = 1'b1;
               state_in   = ST_B_NEXT;
            end
         end
         ST_B_NEXT: begin
            if (status.idx_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_B_READ;
            end
         end
         // hand the result to the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.ld_rsp   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/gated_delta_rule_state_update_top.sv
// ----------------------------------------------------------------------------
// gated_delta_rule_state_update_top
// Gated delta-rule recurrent state update in FP32: element loads and reads
// of the state, query and key, and one-row commits.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | operation, row, column, words
//   rsp     | out       | rsp_valid/rsp_ready   | result_word, result_kind
//   csr     | in        | csr_valid/csr_ready   | key_length
//
// Writes and reads pass through the dispatch and finish states to a waiting result.
// A commit walks each of the L key elements in use through both passes: every
// multiply and add goes one at a time through the one three-stage FPU.
// Reset is synchronous; no memory clearing pass, the block is ready at once.
// A new transaction is taken while the previous result waits in its register.
// ----------------------------------------------------------------------------
module gated_delta_rule_state_update_top
   import gdr_pkg::*;
#(
   parameter int ROWS    = 4,
   parameter int KEY_DIM = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [1:0]  req_row,
   input  logic [6:0]  req_column,
   input  logic [31:0] req_state_word,
   input  logic [31:0] req_query_word,
   input  logic [31:0] req_key_word,
   input  logic [31:0] req_value_word,
   input  logic [31:0] req_decay_word,
   input  logic [31:0] req_beta_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_word,
   output logic [1:0]  rsp_result_kind,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_key_length
);

   gdr_cmd_type    cmd;
   gdr_status_type status;

   assign csr_ready = 1'b1;

   gdr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gdr_datapath #(.ROWS(ROWS), .KEY_DIM(KEY_DIM)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_row         (req_row),
      .req_column      (req_column),
      .req_state_word  (req_state_word),
      .req_query_word  (req_query_word),
      .req_key_word    (req_key_word),
      .req_value_word  (req_value_word),
      .req_decay_word  (req_decay_word),
      .req_beta_word   (req_beta_word),
      .csr_wr          (csr_valid && csr_ready),
      .csr_key_length  (csr_key_length),
      .rsp_result_word (rsp_result_word),
      .rsp_result_kind (rsp_result_kind)
   );

endmodule

// File: rtl/gdr_checker.sv
// ----------------------------------------------------------------------------
// gdr_checker
// Port-level checks of the state update block, bound to the top level.
// ----------------------------------------------------------------------------
`include "gated_delta_rule_state_update_top_assert.svh"

module gdr_checker
   import gdr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_word,
   input logic [1:0]  rsp_result_kind
);

   // a stalled result holds
   `GDR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_result_word) && $stable(rsp_result_kind),
      "stalled result changed")

   // write acknowledges carry a zero word
   `GDR_ASSERT_SAME(a_ack_zero, rsp_valid && (rsp_result_kind == KIND_ACK),
      rsp_result_word == 32'd0, "write acknowledge with nonzero word")

   // one transaction at a time
   `GDR_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
      "transaction accepted while another is in work")

endmodule

bind gated_delta_rule_state_update_top gdr_checker u_checker (.*);
